// File: hdl/xsr_pkg.sv
// ----------------------------------------------------------------------------
// xsr_pkg
// Shared types and constants for the xorshift64* range draw block.
// ----------------------------------------------------------------------------
`default_nettype none

package xsr_pkg;

	localparam int unsigned STATE_W = 64;
	localparam int unsigned RANGE_W = 63;
	localparam int unsigned ENT_W   = 32;
	localparam int unsigned CNT_W   = 6;   // counts the 64 serial steps

	localparam logic [STATE_W-1:0] MIX_MULT = 64'd2685821657736338717;

	// request kinds carried on tuser
	localparam logic REQ_DRAW   = 1'b0;
	localparam logic REQ_RESEED = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} xsr_state_t;

endpackage

`default_nettype wire

// File: hdl/xorshift64star_range_draw.sv
// ----------------------------------------------------------------------------
// xorshift64star_range_draw
// xorshift64* generator with a serial multiplier and a serial remainder unit.
// ----------------------------------------------------------------------------
// Draw: the xorshift is applied as the request is taken, then a serial
//   shift-add multiply (ST_MUL), a serial restoring remainder (ST_DIV) and a
//   load into the output register (ST_OUT); the next request is taken only
//   after that load. A result still held stretches the last step.
// Reseed: serial multiply only, no result; next request taken after it.
// Reset (arst_n low, asynchronous): state 0, range 1, no result pending.
`default_nettype none

module xorshift64star_range_draw (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: range_limit
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [62:0] cfg_data,
	// requests
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] entropy
	input  wire logic [0:0]  s_axis_tuser,   // [0] req_type
	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata    // [62:0] value, [63] zero
);

	localparam int unsigned SW = xsr_pkg::STATE_W;
	localparam int unsigned RW = xsr_pkg::RANGE_W;
	localparam int unsigned CW = xsr_pkg::CNT_W;

	xsr_pkg::xsr_state_t state_q, state_d;

	logic [SW-1:0] gen_q;      // generator state
	logic [RW-1:0] range_q;    // modulus
	logic [SW-1:0] mcand_q;    // multiplicand, shifts left
	logic [SW-1:0] mplier_q;   // constant, shifts right, LSB picks the add
	logic [SW-1:0] acc_q;      // product, then dividend shifting out MSB first
	logic [RW-1:0] rem_q;      // running remainder
	logic [CW-1:0] cnt_q;
	logic          draw_q;     // current request is a draw
	logic [RW-1:0] out_q;
	logic          out_vld_q;

	logic          in_acc;
	logic          last_step;
	logic          load_out;
	logic [SW-1:0] xs_draw;
	logic [SW-1:0] xs_seed;
	logic [SW-1:0] acc_next;
	logic [SW-1:0] trial;
	logic [SW-1:0] trial_sub;
	logic          trial_ge;

	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign last_step     = (cnt_q == {CW{1'b1}});
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {1'b0, out_q};

	// xorshift for a draw (12, 25, 27) and scramble for a reseed (11, 17, 4)
	always_comb begin
		logic [SW-1:0] a;
		logic [SW-1:0] b;
		a = gen_q;
		a = a ^ (a >> 12);
		a = a ^ (a << 25);
		a = a ^ (a >> 27);
		xs_draw = a;
		b = gen_q ^ {{(SW-xsr_pkg::ENT_W){1'b0}}, s_axis_tdata};
		b = b ^ (b >> 11);
		b = b ^ (b << 17);
		b = b ^ (b >> 4);
		xs_seed = b;
	end

	// one shift-add step of the multiply
	assign acc_next = acc_q + (mplier_q[0] ? mcand_q : '0);

	// one restoring remainder step; rem < range < 2^63 so the trial fits
	assign trial     = {rem_q, acc_q[SW-1]};
	assign trial_ge  = (trial >= {1'b0, range_q});
	assign trial_sub = trial - {1'b0, range_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			xsr_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = xsr_pkg::ST_MUL;
			end
			xsr_pkg::ST_MUL: begin
				if (last_step) state_d = draw_q ? xsr_pkg::ST_DIV : xsr_pkg::ST_IDLE;
			end
			xsr_pkg::ST_DIV: begin
				if (last_step) state_d = xsr_pkg::ST_OUT;
			end
			xsr_pkg::ST_OUT: begin
				// wait until the output register is free
				if (!out_vld_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = xsr_pkg::ST_IDLE;
				end
			end
			default: state_d = xsr_pkg::ST_IDLE;
		endcase
	end

	// architectural state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q     <= '0;
			range_q   <= {{(RW-1){1'b0}}, 1'b1};
			out_vld_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) range_q <= cfg_data;

			if (in_acc && (s_axis_tuser[0] == xsr_pkg::REQ_DRAW)) gen_q <= xs_draw;
			else if (state_q == xsr_pkg::ST_MUL && last_step && !draw_q) gen_q <= acc_next;

			if (in_acc) cnt_q <= '0;
			else if (state_q == xsr_pkg::ST_MUL || state_q == xsr_pkg::ST_DIV)
				cnt_q <= cnt_q + 1'b1;

			if (load_out) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
		end
	end

	// serial datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			draw_q   <= (s_axis_tuser[0] == xsr_pkg::REQ_DRAW);
			mcand_q  <= (s_axis_tuser[0] == xsr_pkg::REQ_DRAW) ? xs_draw : xs_seed;
			mplier_q <= xsr_pkg::MIX_MULT;
			acc_q    <= '0;
		end else if (state_q == xsr_pkg::ST_MUL) begin
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
			acc_q    <= acc_next;
			rem_q    <= '0;
		end else if (state_q == xsr_pkg::ST_DIV) begin
			acc_q <= acc_q << 1;
			rem_q <= trial_ge ? trial_sub[RW-1:0] : trial[RW-1:0];
		end

		// zero range reads as range one: result 0
		if (load_out) out_q <= (range_q == '0) ? '0 : rem_q;
	end

endmodule

`default_nettype wire
